### hw/rtl/q2e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types, widths and constants of the quaternion to Euler angle block.
// ----------------------------------------------------------------------------
package q2e_pkg;

   localparam int QUAT_W      = 16;
   localparam int ANGLE_W     = 16;
   localparam int PITCH_W     = 15;
   localparam int PROD_W      = 32;
   localparam int ANG_TAB_LEN = 24;
   localparam int CORDIC_W    = 38;   // datapath width of the vectoring rotations
   localparam int ACC_W       = 25;   // angle accumulator, 1/256 cdeg
   localparam int REM_W       = 61;   // radicand 2^60 - s^2
   localparam int RAD_W       = 62;   // square root working width
   localparam int SQ_STEPS    = 31;   // one result bit per step
   localparam int ROOT_W      = 31;
   localparam int RND_W       = ACC_W + 1;

   localparam logic signed [ACC_W-1:0] HALF_TURN  = 25'sd4608000;
   localparam logic signed [RND_W-1:0] RND_HALF   = 26'sd128;
   localparam logic signed [RND_W-9:0] ANGLE_MAX  = 18'sd18000;
   localparam logic signed [ANGLE_W-1:0] PITCH_MAX = 16'sd9000;
   localparam logic signed [33:0] S_ONE           = 34'sd1073741824;
   localparam logic [REM_W-1:0] ONE_Q60           = {1'b1, {(REM_W-1){1'b0}}};

   typedef struct packed {
      logic signed [33:0] roll_y;
      logic signed [32:0] roll_x;
      logic signed [33:0] yaw_y;
      logic signed [32:0] yaw_x;
      logic signed [33:0] s;
      logic               clamp;
   } q2e_work_type;

   typedef struct packed {
      q2e_work_type     work;
      logic [REM_W-1:0] rem;
   } q2e_item_type;

   // atan(2^-i) in 1/256 cdeg
   function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
      logic signed [ACC_W-1:0] val;
      case (idx)
         0:  val = 25'sd1152000;
         1:  val = 25'sd680065;
         2:  val = 25'sd359328;
         3:  val = 25'sd182400;
         4:  val = 25'sd91554;
         5:  val = 25'sd45822;
         6:  val = 25'sd22916;
         7:  val = 25'sd11459;
         8:  val = 25'sd5730;
         9:  val = 25'sd2865;
         10: val = 25'sd1432;
         11: val = 25'sd716;
         12: val = 25'sd358;
         13: val = 25'sd179;
         14: val = 25'sd90;
         15: val = 25'sd45;
         16: val = 25'sd22;
         17: val = 25'sd11;
         18: val = 25'sd6;
         19: val = 25'sd3;
         20: val = 25'sd1;
         21: val = 25'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### hw/rtl/q2e_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_req_if / q2e_rsp_if
// Valid/ready channels for quaternion transfers and angle transfers.
// ----------------------------------------------------------------------------
interface q2e_req_if;
   import q2e_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [QUAT_W-1:0] qw;
   logic signed [QUAT_W-1:0] qx;
   logic signed [QUAT_W-1:0] qy;
   logic signed [QUAT_W-1:0] qz;
   modport source (output valid, qw, qx, qy, qz, input ready);
   modport sink   (input valid, qw, qx, qy, qz, output ready);
endinterface

interface q2e_rsp_if;
   import q2e_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] roll_cdeg;
   logic signed [PITCH_W-1:0] pitch_cdeg;
   logic signed [ANGLE_W-1:0] yaw_cdeg;
   logic                      pitch_clamped;
   modport source (output valid, roll_cdeg, pitch_cdeg, yaw_cdeg, pitch_clamped,
                   input ready);
   modport sink   (input valid, roll_cdeg, pitch_cdeg, yaw_cdeg, pitch_clamped,
                   output ready);
endinterface

### hw/rtl/q2e_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_front
// Four-stage front end: products, angle operands and asin range check, square, radicand.
// ----------------------------------------------------------------------------
module q2e_front (
   input  logic                  clock,
   input  logic                  reset,
   q2e_req_if.sink               req,
   output logic                  item_valid,
   input  logic                  item_ready,
   output q2e_pkg::q2e_item_type item
);
   import q2e_pkg::*;

   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic signed [PROD_W-1:0] ww_ff, xx_ff, yy_ff, zz_ff, yz_ff, xw_ff, xy_ff, zw_ff,
                             xz_ff, yw_ff;
   q2e_work_type     work2_in, work2_ff, work3_ff, work4_ff;
   logic [REM_W-1:0] ssq_in, ssq_ff, rem_in, rem_ff;

   logic signed [32:0] roll_sum, yaw_sum, diff;
   logic signed [31:0] s_eff;
   logic signed [63:0] s_prod;

   assign adv       = !v4_ff || item_ready;
   assign req.ready = adv;

   always_comb begin
      roll_sum         = 33'(yz_ff) + 33'(xw_ff);
      yaw_sum          = 33'(xy_ff) + 33'(zw_ff);
      diff             = 33'(xz_ff) - 33'(yw_ff);
      work2_in.roll_y  = {roll_sum, 1'b0};
      work2_in.roll_x  = 33'(ww_ff) - 33'(xx_ff) - 33'(yy_ff) + 33'(zz_ff);
      work2_in.yaw_y   = {yaw_sum, 1'b0};
      work2_in.yaw_x   = 33'(ww_ff) + 33'(xx_ff) - 33'(yy_ff) - 33'(zz_ff);
      work2_in.s       = -$signed({diff, 1'b0});
      work2_in.clamp   = (work2_in.s > S_ONE) || (work2_in.s < -S_ONE);
   end

   // zero the operand when out of range so the radicand stays meaningful
   always_comb begin
      s_eff  = work2_ff.clamp ? '0 : work2_ff.s[31:0];
      s_prod = 64'(s_eff) * 64'(s_eff);
      ssq_in = s_prod[REM_W-1:0];
      rem_in = ONE_Q60 - ssq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ww_ff    <= req.qw * req.qw;
         xx_ff    <= req.qx * req.qx;
         yy_ff    <= req.qy * req.qy;
         zz_ff    <= req.qz * req.qz;
         yz_ff    <= req.qy * req.qz;
         xw_ff    <= req.qx * req.qw;
         xy_ff    <= req.qx * req.qy;
         zw_ff    <= req.qz * req.qw;
         xz_ff    <= req.qx * req.qz;
         yw_ff    <= req.qy * req.qw;
         work2_ff <= work2_in;
         work3_ff <= work2_ff;
         ssq_ff   <= ssq_in;
         work4_ff <= work3_ff;
         rem_ff   <= rem_in;
      end
   end

   assign item_valid = v4_ff;
   assign item.work  = work4_ff;
   assign item.rem   = rem_ff;

endmodule

### hw/rtl/q2e_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_fifo
// Small register queue between front end and back end.
// ----------------------------------------------------------------------------
module q2e_fifo #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  logic [W-1:0] push_data,
   output logic         pop_valid,
   input  logic         pop_ready,
   output logic [W-1:0] pop_data
);
   localparam int AW = $clog2(DEPTH);

   logic [W-1:0]  mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign push_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/q2e_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_isqrt
// Pipelined integer square root, one result bit per stage, with side payload.
// ----------------------------------------------------------------------------
module q2e_isqrt #(
   parameter int SIDE_W = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [q2e_pkg::REM_W-1:0]    rem_in,
   input  logic [SIDE_W-1:0]            side_in,
   output logic                         out_valid,
   output logic [q2e_pkg::ROOT_W-1:0]   root_out,
   output logic [SIDE_W-1:0]            side_out
);
   import q2e_pkg::*;

   logic [RAD_W-1:0]  v_ff    [SQ_STEPS+1];
   logic [RAD_W-1:0]  r_ff    [SQ_STEPS+1];
   logic [SIDE_W-1:0] side_ff [SQ_STEPS+1];
   logic              val_ff  [SQ_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (en) begin
         val_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff[0]    <= RAD_W'(rem_in);
         r_ff[0]    <= '0;
         side_ff[0] <= side_in;
      end
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQ_STEPS - 1 - k));
      logic [RAD_W-1:0] t, v_in, r_in;

      always_comb begin
         t = r_ff[k] + BIT;
         if (v_ff[k] >= t) begin
            v_in = v_ff[k] - t;
            r_in = (r_ff[k] >> 1) + BIT;
         end else begin
            v_in = v_ff[k];
            r_in = r_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k+1] <= 1'b0;
         end else if (en) begin
            val_ff[k+1] <= val_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[k+1]    <= v_in;
            r_ff[k+1]    <= r_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = val_ff[SQ_STEPS];
   assign root_out  = r_ff[SQ_STEPS][ROOT_W-1:0];
   assign side_out  = side_ff[SQ_STEPS];

endmodule

### hw/rtl/q2e_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring atan2 in cdeg, one rotation per stage, clamped to +/-180.
// ----------------------------------------------------------------------------
module q2e_cordic #(
   parameter int NSTEPS = 16
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [q2e_pkg::CORDIC_W-1:0] y_in,
   input  logic signed [q2e_pkg::CORDIC_W-1:0] x_in,
   output logic signed [q2e_pkg::ANGLE_W-1:0]  angle_out
);
   import q2e_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff [NSTEPS+1];
   logic signed [CORDIC_W-1:0] y_ff [NSTEPS+1];
   logic signed [ACC_W-1:0]    a_ff [NSTEPS+1];
   logic                       z_ff [NSTEPS+1];

   logic signed [ANGLE_W-1:0]  angle_ff, angle_in;
   logic signed [RND_W-1:0]    rnd;
   logic signed [RND_W-9:0]    coarse;

   // fold the left half plane onto the right one
   always_ff @(posedge clock) begin
      if (en) begin
         z_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            x_ff[0] <= -x_in;
            y_ff[0] <= -y_in;
            a_ff[0] <= (y_in >= 0) ? HALF_TURN : -HALF_TURN;
         end else begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            a_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < NSTEPS; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (en) begin
            z_ff[i+1] <= z_ff[i];
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               a_ff[i+1] <= a_ff[i] + atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               a_ff[i+1] <= a_ff[i] - atan_entry(i);
            end
         end
      end
   end

   // round to cdeg and clamp
   always_comb begin
      rnd    = RND_W'(a_ff[NSTEPS]) + RND_HALF;
      coarse = rnd[RND_W-1:8];
      if (z_ff[NSTEPS]) begin
         angle_in = '0;
      end else if (coarse > ANGLE_MAX) begin
         angle_in = ANGLE_MAX[ANGLE_W-1:0];
      end else if (coarse < -ANGLE_MAX) begin
         angle_in = -ANGLE_MAX[ANGLE_W-1:0];
      end else begin
         angle_in = coarse[ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign angle_out = angle_ff;

endmodule

### hw/rtl/quaternion_to_euler_angles_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Q1.15 quaternion in, roll/pitch/yaw in hundredths of a degree out.
// ----------------------------------------------------------------------------
// One quaternion transfer is taken per clock and one angle transfer leaves per
// clock while the response side keeps ready high; there is no state between
// items. A request passes through four front stages (products, angle operands
// and asin range check, square, radicand), the queue, the 31-step square root
// that turns sin(pitch) into cos(pitch), and the CORDIC rotation pipelines, one
// stage per iteration (at most 24). The front end keeps taking transfers while
// the response stalls until the four-entry queue and its own stages are full.
// When the asin argument leaves [-1, 1] pitch saturates to +/-9000 and
// pitch_clamped is set. Both atan2 operands zero give angle 0.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic     clock,
   input  logic     reset,
   q2e_req_if.sink  req_chan,
   q2e_rsp_if.source rsp_chan
);
   import q2e_pkg::*;

   // more than the table length runs the whole table
   localparam int NSTEPS = (CORDIC_STEPS > ANG_TAB_LEN) ? ANG_TAB_LEN : CORDIC_STEPS;
   localparam int CLAT   = NSTEPS + 2;
   localparam int SIDE_W = $bits(q2e_work_type);

   logic         item_valid, item_ready, q_valid, back_adv;
   q2e_item_type item, q_item;

   logic               sq_valid;
   logic [ROOT_W-1:0]  root;
   logic [SIDE_W-1:0]  side_raw;
   q2e_work_type       side;

   logic signed [ANGLE_W-1:0] roll_ang, pitch_ang, yaw_ang;
   logic                      val_ff [CLAT];
   logic                      clamp_ff [CLAT];
   logic                      neg_ff [CLAT];
   logic signed [ANGLE_W-1:0] pitch_sel;

   // front end: accept and classify
   q2e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   // queue decouples the two halves
   q2e_fifo #(.W($bits(q2e_item_type)), .DEPTH(4)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (item_valid),
      .push_ready (item_ready),
      .push_data  (item),
      .pop_valid  (q_valid),
      .pop_ready  (back_adv),
      .pop_data   (q_item)
   );

   // back end advances whenever the output register is free or drained
   assign back_adv = !val_ff[CLAT-1] || rsp_chan.ready;

   q2e_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (back_adv),
      .in_valid  (q_valid),
      .rem_in    (q_item.rem),
      .side_in   (q_item.work),
      .out_valid (sq_valid),
      .root_out  (root),
      .side_out  (side_raw)
   );

   assign side = side_raw;

   q2e_cordic #(.NSTEPS(NSTEPS)) u_roll (
      .clock     (clock),
      .en        (back_adv),
      .y_in      (CORDIC_W'(side.roll_y)),
      .x_in      (CORDIC_W'(side.roll_x)),
      .angle_out (roll_ang)
   );

   q2e_cordic #(.NSTEPS(NSTEPS)) u_pitch (
      .clock     (clock),
      .en        (back_adv),
      .y_in      (CORDIC_W'(side.s)),
      .x_in      (CORDIC_W'({1'b0, root})),
      .angle_out (pitch_ang)
   );

   q2e_cordic #(.NSTEPS(NSTEPS)) u_yaw (
      .clock     (clock),
      .en        (back_adv),
      .y_in      (CORDIC_W'(side.yaw_y)),
      .x_in      (CORDIC_W'(side.yaw_x)),
      .angle_out (yaw_ang)
   );

   // carry valid and the saturation decision alongside the rotations
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CLAT; i++) begin
            val_ff[i] <= 1'b0;
         end
      end else if (back_adv) begin
         val_ff[0] <= sq_valid;
         for (int i = 1; i < CLAT; i++) begin
            val_ff[i] <= val_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (back_adv) begin
         clamp_ff[0] <= side.clamp;
         neg_ff[0]   <= side.s[33];
         for (int i = 1; i < CLAT; i++) begin
            clamp_ff[i] <= clamp_ff[i-1];
            neg_ff[i]   <= neg_ff[i-1];
         end
      end
   end

   // saturate pitch: forced on range overflow, otherwise held within +/-90
   always_comb begin
      if (clamp_ff[CLAT-1]) begin
         pitch_sel = neg_ff[CLAT-1] ? -PITCH_MAX : PITCH_MAX;
      end else if (pitch_ang > PITCH_MAX) begin
         pitch_sel = PITCH_MAX;
      end else if (pitch_ang < -PITCH_MAX) begin
         pitch_sel = -PITCH_MAX;
      end else begin
         pitch_sel = pitch_ang;
      end
   end

   assign rsp_chan.valid         = val_ff[CLAT-1];
   assign rsp_chan.roll_cdeg     = roll_ang;
   assign rsp_chan.pitch_cdeg    = pitch_sel[PITCH_W-1:0];
   assign rsp_chan.yaw_cdeg      = yaw_ang;
   assign rsp_chan.pitch_clamped = clamp_ff[CLAT-1];

endmodule

### dv/tb_quaternion_to_euler_angles_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles_top
// Self-checking bench for the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
// Quaternion transfers go in through bursts with random gaps, while the
// response side stalls on a pattern of its own. An integer CORDIC predictor
// works out roll, pitch, yaw and the saturation flag for every accepted
// quaternion and queues them. A monitor compares each response transfer
// field by field with the oldest queued expectation.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles_top;
   import q2e_pkg::*;

   localparam int STEPS = 16;
   localparam longint ONE_Q30_L = 64'sd1073741824;
   localparam longint HALF_ACC  = 64'sd4608000;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] roll;
      logic signed [PITCH_W-1:0] pitch;
      logic signed [ANGLE_W-1:0] yaw;
      logic                      clamped;
   } angles_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   q2e_req_if req_chan ();
   q2e_rsp_if rsp_chan ();

   quaternion_to_euler_angles_top #(.CORDIC_STEPS(STEPS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #4 clock = ~clock;

   angles_type angle_queue[$];
   int      error_count = 0;
   int      quat_count  = 0;
   int      angle_count = 0;
   int      clamp_count = 0;
   bit      long_hold   = 1'b0;
   bit      stall_on    = 1'b1;
   int      burst_left  = 0;

   // atan(2^-i) in 1/256 cdeg
   function automatic longint atan_step(int idx);
      longint tab[24] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
                          11459, 5730, 2865, 1432, 716, 358, 179, 90, 45,
                          22, 11, 6, 3, 1, 1, 0, 0};
      return tab[idx];
   endfunction

   // floor shift; >>> on a signed longint already floors
   function automatic longint vector_angle(longint yv, longint xv);
      longint acc;
      longint nx;
      longint ny;
      longint r;
      int     n;
      acc = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
         acc = (yv >= 0) ? HALF_ACC : -HALF_ACC;
         xv = -xv;
         yv = -yv;
      end
      n = (STEPS > 24) ? 24 : STEPS;
      for (int i = 0; i < n; i++) begin
         if (yv > 0) begin
            nx = xv + (yv >>> i);
            ny = yv - (xv >>> i);
            acc += atan_step(i);
         end else begin
            nx = xv - (yv >>> i);
            ny = yv + (xv >>> i);
            acc -= atan_step(i);
         end
         xv = nx;
         yv = ny;
      end
      r = (acc + 128) >>> 8;
      if (r > 18000) r = 18000;
      if (r < -18000) r = -18000;
      return r;
   endfunction

   function automatic longint int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v  -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic angles_type predict_angles(logic signed [15:0] qw, qx, qy, qz);
      longint  w, x, y, z, s, p;
      logic [63:0] rem;
      angles_type a;
      w = qw; x = qx; y = qy; z = qz;
      a.roll = 16'(vector_angle(2 * (y * z + x * w), w*w - x*x - y*y + z*z));
      a.yaw  = 16'(vector_angle(2 * (x * y + z * w), w*w + x*x - y*y - z*z));
      s = -2 * (x * z - y * w);
      a.clamped = 1'b0;
      if (s > ONE_Q30_L) begin
         p = 9000; a.clamped = 1'b1;
      end else if (s < -ONE_Q30_L) begin
         p = -9000; a.clamped = 1'b1;
      end else begin
         rem = (64'd1 << 60) - 64'(s * s);
         p = vector_angle(s, int_sqrt(rem));
         if (p > 9000) p = 9000;
         if (p < -9000) p = -9000;
      end
      a.pitch = 15'(p);
      return a;
   endfunction

   // record the expectation for every accepted quaternion
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         angle_queue.push_back(predict_angles(req_chan.qw, req_chan.qx,
                                              req_chan.qy, req_chan.qz));
         quat_count++;
      end
   end

   // compare every response transfer against the oldest expectation
   always @(posedge clock) begin
      angles_type exp_a;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         angle_count++;
         if (angle_queue.size() == 0) begin
            $display("%0t: unexpected response roll=%0d pitch=%0d yaw=%0d flag=%0b",
                     $time, rsp_chan.roll_cdeg, rsp_chan.pitch_cdeg,
                     rsp_chan.yaw_cdeg, rsp_chan.pitch_clamped);
            error_count++;
         end else begin
            exp_a = angle_queue.pop_front();
            if (exp_a.clamped) clamp_count++;
            if (rsp_chan.roll_cdeg !== exp_a.roll) begin
               $display("%0t: roll expected %0d actual %0d", $time, exp_a.roll,
                        rsp_chan.roll_cdeg);
               error_count++;
            end
            if (rsp_chan.pitch_cdeg !== exp_a.pitch) begin
               $display("%0t: pitch expected %0d actual %0d", $time, exp_a.pitch,
                        rsp_chan.pitch_cdeg);
               error_count++;
            end
            if (rsp_chan.yaw_cdeg !== exp_a.yaw) begin
               $display("%0t: yaw expected %0d actual %0d", $time, exp_a.yaw,
                        rsp_chan.yaw_cdeg);
               error_count++;
            end
            if (rsp_chan.pitch_clamped !== exp_a.clamped) begin
               $display("%0t: pitch_clamped expected %0b actual %0b", $time,
                        exp_a.clamped, rsp_chan.pitch_clamped);
               error_count++;
            end
         end
      end
   end

   // receiver: random stall pattern, with stretches of steady ready, and a long
   // hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (long_hold) begin
         rsp_chan.ready <= 1'b0;
      end else if (!stall_on) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.qw = '0; req_chan.qx = '0; req_chan.qy = '0; req_chan.qz = '0;
   end

   // send one quaternion; hold valid until the transfer, with burst gaps
   task automatic send_quat(input logic [15:0] w, x, y, z);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if (stall_on && $urandom_range(0, 1)) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.qw <= w; req_chan.qx <= x; req_chan.qy <= y; req_chan.qz <= z;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic idle_sender();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed();
      logic [15:0] edge_vals[8] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001,
                                    16'hFFFF, 16'h5A82, 16'hA57E, 16'h4000};
      // identity, all zero, extremes, unit rotations about each axis
      send_quat(16'h7FFF, 0, 0, 0);
      send_quat(0, 0, 0, 0);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_quat(0, 16'h7FFF, 0, 0);
      send_quat(0, 16'h8000, 0, 0);
      send_quat(0, 0, 16'h7FFF, 0);
      send_quat(0, 0, 0, 16'h7FFF);
      // gimbal lock: asin argument at +/-0.5 and beyond +/-1.0
      send_quat(16'h4000, 0, 16'h4000, 0);
      send_quat(16'h4000, 0, 16'hC000, 0);
      send_quat(16'h7FFF, 0, 16'h7FFF, 0);
      send_quat(16'h7FFF, 0, 16'h8000, 0);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
      // negative x operand with zero y operand: half turn
      send_quat(0, 16'h4000, 16'h4000, 0);
      for (int i = 0; i < 10; i++)
         send_quat(edge_vals[$urandom_range(0, 7)], edge_vals[$urandom_range(0, 7)],
                   edge_vals[$urandom_range(0, 7)], edge_vals[$urandom_range(0, 7)]);
      idle_sender();
   endtask

   task automatic test_random(input int n);
      logic [15:0] v[4];
      for (int i = 0; i < n; i++) begin
         for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 3))
               0:       v[k] = 16'($urandom_range(0, 16'hFFFF));
               1:       v[k] = 16'($signed(11'($urandom)));  // small magnitude
               default: v[k] = 16'($signed(15'($urandom)));  // magnitude up to 0.5
            endcase
         end
         send_quat(v[0], v[1], v[2], v[3]);
      end
      idle_sender();
   endtask

   // stall the response side long enough for the pipeline to back up
   task automatic test_backpressure();
      fork
         begin
            long_hold = 1'b1;
            repeat (200) @(posedge clock);
            long_hold = 1'b0;
         end
         test_random(150);
      join
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (angle_queue.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (80) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(700);
      stall_on = 1'b0;
      test_random(300);
      stall_on = 1'b1;
      test_backpressure();
      test_random(600);
      drain();
      $display("Covered %0d quaternions, %0d responses, %0d with saturated pitch.",
               quat_count, angle_count, clamp_count);
      $display("Stimulus: edge values, gimbal lock, random bursts, long response stall.");
      if (error_count == 0 && angle_queue.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         if (angle_queue.size() != 0)
            $display("%0t: %0d expected responses never arrived", $time,
                     angle_queue.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("%0t: timeout", $time);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
